[src/angular_duplicate_merge_table_macros.svh]
// Assertion macros shared by the merge table checker.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ANGULAR_DUPLICATE_MERGE_TABLE_MACROS_SVH
`define ANGULAR_DUPLICATE_MERGE_TABLE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ADM_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ADM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/adm_pkg.sv]
// Shared types and constants of the angular duplicate merge table.
// No dependencies; every other RTL file imports this package.
package adm_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int CLASS_COUNT = 80;

	localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

	localparam int CLASS_W = 7;
	localparam int SCORE_W = 16;
	localparam int YAW_W   = 15;
	localparam int PITCH_W = 14;
	localparam int VIEW_W  = 2;
	localparam int TOL_W   = 14;

	localparam int DATA_W     = 56;
	localparam int USER_IN_W  = 1;
	localparam int USER_OUT_W = 2;
	localparam int CFG_IDX_W  = 2;

	// Angles in 1/64 degree: half turn is 180 degrees, full turn 360 degrees
	localparam logic [YAW_W+1:0] HALF_TURN = 17'd11520;
	localparam logic [YAW_W+1:0] FULL_TURN = 17'd23040;

	localparam logic [TOL_W-1:0] TOL_RESET = 14'd320;

	localparam logic [CLASS_W:0] CLASS_LIMIT = (CLASS_W + 1)'(CLASS_COUNT);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_FLUSH  = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_YAW_TOL   = 2'd0,
		REG_PITCH_TOL = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FL_RD,
		ST_FL_LD
	} state_t;

	typedef struct packed {
		logic [CLASS_W-1:0]        cls;
		logic [SCORE_W-1:0]        score;
		logic signed [YAW_W-1:0]   yaw;
		logic signed [PITCH_W-1:0] pitch;
		logic [VIEW_W-1:0]         view;
	} entry_t;

	typedef struct packed {
		logic valid;
		logic hit;
		logic score_gt;
	} match_t;

endpackage

[src/adm_ram.sv]
// Entry storage of the merge table: one write port, one read port,
// registered read data. Depends on adm_pkg.
module adm_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [adm_pkg::ADDR_W-1:0] waddr,
	input  adm_pkg::entry_t            wdata,
	input  logic [adm_pkg::ADDR_W-1:0] raddr,
	output adm_pkg::entry_t            rdata
);
	import adm_pkg::*;

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[src/adm_match.sv]
// Two-step duplicate test of one stored entry against the pending detection:
// distances are registered, then compared with the tolerances. Depends on adm_pkg.
module adm_match (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  adm_pkg::entry_t           entry,
	input  adm_pkg::entry_t           item,
	input  logic [adm_pkg::TOL_W-1:0] yaw_tol,
	input  logic [adm_pkg::TOL_W-1:0] pitch_tol,
	output adm_pkg::match_t           res
);
	import adm_pkg::*;

	logic signed [YAW_W:0]   ya, yb;
	logic signed [PITCH_W:0] pa, pb;
	logic [YAW_W:0]          yd;
	logic [PITCH_W:0]        pd;
	logic                    cls_eq, gt;

	logic                    valid_s2;
	logic [YAW_W:0]          yd_s2;
	logic [PITCH_W:0]        pd_s2;
	logic                    cls_eq_s2, gt_s2;

	logic [YAW_W+1:0]        yd_w, ytol_w;
	logic                    near_ok, far_ok, pitch_ok;

	always_comb begin
		ya = (YAW_W + 1)'(entry.yaw);
		yb = (YAW_W + 1)'(item.yaw);
		pa = (PITCH_W + 1)'(entry.pitch);
		pb = (PITCH_W + 1)'(item.pitch);
		yd = (ya > yb) ? (ya - yb) : (yb - ya);
		pd = (pa > pb) ? (pa - pb) : (pb - pa);
		cls_eq = (entry.cls == item.cls);
		gt = (item.score > entry.score);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		yd_s2     <= yd;
		pd_s2     <= pd;
		cls_eq_s2 <= cls_eq;
		gt_s2     <= gt;
	end

	// Past a half turn the gap folds to |full turn - d|, which is below the
	// tolerance exactly when d lies strictly inside full turn +/- tolerance.
	always_comb begin
		yd_w     = {1'b0, yd_s2};
		ytol_w   = (YAW_W + 2)'(yaw_tol);
		near_ok  = (yd_w <= HALF_TURN) && (yd_w < ytol_w);
		far_ok   = (yd_w > HALF_TURN) && (yd_w > FULL_TURN - ytol_w)
			&& (yd_w < FULL_TURN + ytol_w);
		pitch_ok = (pd_s2 < {1'b0, pitch_tol});
		res.valid    = valid_s2;
		res.hit      = valid_s2 && cls_eq_s2 && (near_ok || far_ok) && pitch_ok;
		res.score_gt = gt_s2;
	end

endmodule

[src/angular_duplicate_merge_table.sv]
// Angular duplicate merge table: control, configuration and output register.
// Depends on adm_pkg, adm_ram and adm_match.
//
// Input channel s_*: one transfer per detection (s_tuser = 0) or flush
// (s_tuser = 1). An insert walks the stored entries in order, one entry per
// cycle through the entry RAM and the two-step match unit; it occupies the
// block until every stored entry is compared, ending early on a hit.
// A flush streams the entries out on m_*, each result taking a RAM read
// then an output load; an empty table gives one result with m_tuser[0] = 0.
// m_tlast marks the final result of a flush; m_tuser[1] is the overflow
// flag. The output register lets an insert be taken while a result waits;
// a stalled receiver holds the flush at its next RAM read. Configuration
// writes on cfg_* are taken every cycle; the user makes them only while
// the block idles, which the block does not enforce. Reset empties the
// table, clears overflow and sets both tolerances to 320 (five degrees);
// the entry RAM needs no clearing pass.
module angular_duplicate_merge_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// cls[6:0], score[22:7], yaw[37:23], pitch[51:38], view_id[53:52]
	input  logic [adm_pkg::DATA_W-1:0]      s_tdata,
	// op[0]
	input  logic [adm_pkg::USER_IN_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_class[6:0], out_score[22:7], out_yaw[37:23], out_pitch[51:38],
	// out_view[53:52]
	output logic [adm_pkg::DATA_W-1:0]      m_tdata,
	// entry_valid[0], overflow[1]
	output logic [adm_pkg::USER_OUT_W-1:0]  m_tuser,
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [adm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [adm_pkg::TOL_W-1:0]       cfg_data
);
	import adm_pkg::*;

	state_t            state_q, state_d;
	entry_t            item_q, in_item, ram_rdata, ram_wdata;
	logic [CNT_W-1:0]  cnt_q, idx_q;
	logic              drop_q;
	logic              rd_v_s1;
	logic [ADDR_W-1:0] idx_s1, idx_s2;
	logic [TOL_W-1:0]  ytol_q, ptol_q;

	logic              out_valid_q, out_ev_q, out_ovf_q, out_last_q;
	entry_t            out_data_q;

	match_t            mres;
	logic              accept, is_flush, cls_ok;
	logic              scan_more, scan_done, issue, hit, full;
	logic              ram_we, out_free, fl_load, fl_last, match_in_valid;
	logic [ADDR_W-1:0] ram_waddr;

	assign in_item.cls   = s_tdata[6:0];
	assign in_item.score = s_tdata[22:7];
	assign in_item.yaw   = s_tdata[37:23];
	assign in_item.pitch = s_tdata[51:38];
	assign in_item.view  = s_tdata[53:52];

	assign is_flush  = (op_t'(s_tuser[0]) == OP_FLUSH);
	assign cls_ok    = ({1'b0, in_item.cls} < CLASS_LIMIT);
	assign accept    = s_tvalid && s_tready;
	assign scan_more = (idx_q < cnt_q);
	assign full      = (cnt_q >= CNT_W'(TABLE_DEPTH));
	assign hit       = (state_q == ST_SCAN) && mres.hit;
	assign out_free  = !out_valid_q || m_tready;
	assign fl_last   = (cnt_q == '0) || (idx_q + CNT_W'(1) == cnt_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (is_flush) begin
						state_d = ST_FL_RD;
					end else if (cls_ok) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (hit || scan_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_FL_RD: begin
				if (out_free) begin
					state_d = ST_FL_LD;
				end
			end
			ST_FL_LD: begin
				state_d = fl_last ? ST_IDLE : ST_FL_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the state machine
	always_comb begin
		s_tready  = 1'b0;
		issue     = 1'b0;
		scan_done = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_s2;
		fl_load   = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_SCAN: begin
				issue     = scan_more && !hit;
				scan_done = !hit && !scan_more && !rd_v_s1 && !mres.valid;
				if (hit) begin
					ram_we = mres.score_gt;
				end else if (scan_done) begin
					ram_we    = !full;
					ram_waddr = idx_q[ADDR_W-1:0];
				end
			end
			ST_FL_RD: ;
			ST_FL_LD: fl_load = 1'b1;
			default: ;
		endcase
	end

	assign ram_wdata      = item_q;
	assign match_in_valid = rd_v_s1 && (state_q == ST_SCAN) && !hit;

	adm_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	adm_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (match_in_valid),
		.entry     (ram_rdata),
		.item      (item_q),
		.yaw_tol   (ytol_q),
		.pitch_tol (ptol_q),
		.res       (mres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			drop_q      <= 1'b0;
			rd_v_s1     <= 1'b0;
			ytol_q      <= TOL_RESET;
			ptol_q      <= TOL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			if (accept) begin
				idx_q <= '0;
			end else if (issue || (fl_load && !fl_last)) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (scan_done) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (fl_load && fl_last) begin
				cnt_q  <= '0;
				drop_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_YAW_TOL) begin
					ytol_q <= cfg_data;
				end else if (cfg_index == REG_PITCH_TOL) begin
					ptol_q <= cfg_data;
				end
			end
			// The flush loads only once the register is free, so a load never
			// overwrites a pending result.
			if (fl_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
		end
		idx_s1 <= idx_q[ADDR_W-1:0];
		idx_s2 <= idx_s1;
		if (fl_load) begin
			out_ev_q   <= (cnt_q != '0);
			out_data_q <= (cnt_q != '0) ? ram_rdata : '0;
			out_ovf_q  <= drop_q;
			out_last_q <= fl_last;
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {2'b00, out_data_q.view, out_data_q.pitch, out_data_q.yaw,
		out_data_q.score, out_data_q.cls};
	assign m_tuser   = {out_ovf_q, out_ev_q};
	assign m_tlast   = out_last_q;

endmodule

[src/adm_checker.sv]
// Port-level checks of the merge table, bound to the top level.
// Depends on adm_pkg and angular_duplicate_merge_table_macros.svh.
`include "angular_duplicate_merge_table_macros.svh"

module adm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [adm_pkg::USER_IN_W-1:0]   s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [adm_pkg::DATA_W-1:0]      m_tdata,
	input logic [adm_pkg::USER_OUT_W-1:0]  m_tuser,
	input logic                            m_tlast
);
	import adm_pkg::*;

	// A stalled result holds until its transfer.
	`ADM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

	// The empty-table marker is the only result of its flush and carries zeros.
	`ADM_ASSERT_NOW(a_empty_marker, m_tvalid && !m_tuser[0], m_tlast && (m_tdata == '0), "malformed empty marker")

	// A flush transfer occupies the block.
	`ADM_ASSERT_NEXT(a_flush_busy, s_tvalid && s_tready && (op_t'(s_tuser[0]) == OP_FLUSH), !s_tready, "input taken right after a flush")

endmodule

bind angular_duplicate_merge_table adm_checker u_adm_checker (.*);
